// ===== design/tss_pkg.sv =====
// Shared constants, types and a saturation helper for the tridiagonal solver.
`timescale 1ns / 1ps
`default_nettype none
package tss_pkg;

  localparam int DW        = 32;                 // Q format word width
  localparam int FRAC_BITS = 16;                 // fractional bits
  localparam int MAX_ROWS  = 64;                 // largest system
  localparam int IDXW      = $clog2(MAX_ROWS);   // row index width
  localparam int CNTW      = IDXW + 1;           // row count width
  localparam int PRODW     = 2 * DW;             // full product width
  localparam int SUBW      = PRODW - FRAC_BITS + 1;
  localparam int NUMW      = DW + FRAC_BITS;     // shifted dividend width
  localparam int DCW       = $clog2(NUMW);       // divider step counter width

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_MUL_U    = 12'b0000_0000_0010,
    ST_MUL_D    = 12'b0000_0000_0100,
    ST_NUM      = 12'b0000_0000_1000,
    ST_DIV_INIT = 12'b0000_0001_0000,
    ST_DIV_RUN  = 12'b0000_0010_0000,
    ST_DIV_DONE = 12'b0000_0100_0000,
    ST_BS_RD    = 12'b0000_1000_0000,
    ST_BS_MUL   = 12'b0001_0000_0000,
    ST_BS_SUB   = 12'b0010_0000_0000,
    ST_EM_RD    = 12'b0100_0000_0000,
    ST_EM_LOAD  = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          ovf;
  } sat_t;

  // a - floor(p / 2^FRAC_BITS), saturated to DW bits signed
  function automatic sat_t sub_sat(input logic [DW-1:0] a, input logic [PRODW-1:0] p);
    logic [SUBW-1:0] diff;
    sat_t            res;
    diff = {{(SUBW-DW){a[DW-1]}}, a} - {p[PRODW-1], p[PRODW-1:FRAC_BITS]};
    res.ovf = !((&diff[SUBW-1:DW-1]) || !(|diff[SUBW-1:DW-1]));
    if (res.ovf) begin
      res.val = diff[SUBW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      res.val = diff[DW-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== design/tridiagonal_system_solver.sv =====
// Tridiagonal system solver: Thomas algorithm over Q16.16 rows, one shared divider.
//
//  channel | dir | handshake            | beat
//  in_     | in  | in_valid / in_ready  | one matrix row plus last-row flag
//  out_    | out | out_valid/ out_ready | one solution element with its index
//
//  A row after the first passes through the multiply states and then the radix-2
//  divider, which runs twice per row (one quotient bit per cycle). Row 0 skips the
//  multiply states; a zero pivot skips the divider steps.
//  After the last row, back substitution steps each element through read, multiply
//  and subtract states, then each result passes a store read and the output register.
//  Reset is synchronous, active low; the row stores need no clearing pass.
//  A stalled result holds in the output register; in_ready is high only in idle.
`timescale 1ns / 1ps
`default_nettype none
module tridiagonal_system_solver (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [tss_pkg::DW-1:0]   in_sub_diag,
  input  wire logic signed [tss_pkg::DW-1:0]   in_main_diag,
  input  wire logic signed [tss_pkg::DW-1:0]   in_super_diag,
  input  wire logic signed [tss_pkg::DW-1:0]   in_rhs,
  input  wire logic                            in_last_row,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [tss_pkg::DW-1:0]        out_solution,
  output logic        [tss_pkg::IDXW-1:0]      out_row_index,
  output logic                                 out_last_result,
  output logic                                 out_singular
);

  localparam int DW   = tss_pkg::DW;
  localparam int IDXW = tss_pkg::IDXW;
  localparam int NUMW = tss_pkg::NUMW;
  localparam int DCW  = tss_pkg::DCW;

  tss_pkg::state_t state_r;

  // row stores
  logic [DW-1:0] u_mem [tss_pkg::MAX_ROWS];
  logic [DW-1:0] d_mem [tss_pkg::MAX_ROWS];
  logic [DW-1:0] u_q, d_q;
  logic [IDXW-1:0] rd_addr, d_wr_addr;
  logic [DW-1:0] d_wr_data;
  logic          d_wr_en, u_wr_en;

  // control
  logic [tss_pkg::CNTW-1:0] row_count_r;
  logic                     sing_r;
  logic [IDXW-1:0]          idx_r, k_r, idx_in;
  logic                     last_r;

  // row operands and intermediates
  logic signed [DW-1:0] l_r, c_r, r_r, dv_r, piv_r, num_r, x_r;

  // shared multiplier
  logic signed [DW-1:0]            mul_a, mul_b;
  logic signed [tss_pkg::PRODW-1:0] prod_r;

  // shared divider
  logic              div_sel_r;
  logic [NUMW-1:0]   sh_r;
  logic [DW-1:0]     rem_r, den_mag_r;
  logic [DCW-1:0]    div_cnt_r;
  logic              qneg_r;
  logic [DW-1:0]     dnum, dnum_mag, piv_mag;
  logic [DW:0]       trial;
  logic              take;
  logic [DW-1:0]     q_val;
  logic              q_ovf;

  tss_pkg::sat_t piv_s, num_s, bs_s;

  logic out_valid_r, out_load;

  assign in_ready  = (state_r == tss_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign idx_in    = row_count_r[IDXW] ? IDXW'(tss_pkg::MAX_ROWS - 1) : row_count_r[IDXW-1:0];

  // pick the read address for the stores
  always_comb begin
    unique case (state_r)
      tss_pkg::ST_IDLE:  rd_addr = idx_in - IDXW'(1);
      tss_pkg::ST_MUL_U: rd_addr = idx_r - IDXW'(1);
      default:           rd_addr = k_r;
    endcase
  end

  // registered store reads and writes
  always_ff @(posedge clk) begin
    u_q <= u_mem[rd_addr];
    d_q <= d_mem[rd_addr];
    if (u_wr_en) begin
      u_mem[idx_r] <= q_val;
    end
    if (d_wr_en) begin
      d_mem[d_wr_addr] <= d_wr_data;
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (state_r)
      tss_pkg::ST_MUL_U: begin mul_a = l_r;        mul_b = u_q; end
      tss_pkg::ST_MUL_D: begin mul_a = l_r;        mul_b = d_q; end
      default:           begin mul_a = u_q;        mul_b = x_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign piv_s = tss_pkg::sub_sat(c_r, prod_r);
  assign num_s = tss_pkg::sub_sat(dv_r, prod_r);
  assign bs_s  = tss_pkg::sub_sat(d_q, prod_r);

  // divider operands and one restoring step
  assign dnum     = div_sel_r ? num_r : r_r;
  assign dnum_mag = dnum[DW-1] ? (~dnum + DW'(1)) : dnum;
  assign piv_mag  = piv_r[DW-1] ? (~piv_r + DW'(1)) : piv_r;
  assign trial    = {rem_r, sh_r[NUMW-1]};
  assign take     = (trial >= {1'b0, den_mag_r});

  // final quotient: zero pivot, saturation, sign
  always_comb begin
    if (piv_r == '0) begin
      q_ovf = 1'b1;
      if (dnum == '0)     q_val = '0;
      else if (dnum[DW-1]) q_val = {1'b1, {(DW-1){1'b0}}};
      else                q_val = {1'b0, {(DW-1){1'b1}}};
    end else if (!qneg_r) begin
      q_ovf = |sh_r[NUMW-1:DW-1];
      q_val = q_ovf ? {1'b0, {(DW-1){1'b1}}} : sh_r[DW-1:0];
    end else begin
      q_ovf = (|sh_r[NUMW-1:DW]) || (sh_r[DW-1] && (|sh_r[DW-2:0]));
      q_val = q_ovf ? {1'b1, {(DW-1){1'b0}}} : (~sh_r[DW-1:0] + DW'(1));
    end
  end

  assign u_wr_en   = (state_r == tss_pkg::ST_DIV_DONE) && !div_sel_r;
  assign d_wr_en   = ((state_r == tss_pkg::ST_DIV_DONE) && div_sel_r) ||
                     (state_r == tss_pkg::ST_BS_SUB);
  assign d_wr_addr = (state_r == tss_pkg::ST_BS_SUB) ? k_r : idx_r;
  assign d_wr_data = (state_r == tss_pkg::ST_BS_SUB) ? bs_s.val : q_val;

  assign out_load = (state_r == tss_pkg::ST_EM_LOAD) && (!out_valid_r || out_ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tss_pkg::ST_IDLE;
      row_count_r <= '0;
      sing_r      <= 1'b0;
      div_cnt_r   <= '0;
      div_sel_r   <= 1'b0;
    end else begin
      unique case (state_r)
        tss_pkg::ST_IDLE: begin
          if (in_valid) begin
            l_r    <= in_sub_diag;
            c_r    <= in_main_diag;
            r_r    <= in_super_diag;
            dv_r   <= in_rhs;
            last_r <= in_last_row;
            idx_r  <= idx_in;
            if (idx_in == '0) begin
              piv_r   <= in_main_diag;
              num_r   <= in_rhs;
              state_r <= tss_pkg::ST_DIV_INIT;
            end else begin
              state_r <= tss_pkg::ST_MUL_U;
            end
            div_sel_r <= 1'b0;
          end
        end
        tss_pkg::ST_MUL_U: state_r <= tss_pkg::ST_MUL_D;
        tss_pkg::ST_MUL_D: begin
          piv_r   <= piv_s.val;
          sing_r  <= sing_r | piv_s.ovf;
          state_r <= tss_pkg::ST_NUM;
        end
        tss_pkg::ST_NUM: begin
          num_r   <= num_s.val;
          sing_r  <= sing_r | num_s.ovf;
          state_r <= tss_pkg::ST_DIV_INIT;
        end
        tss_pkg::ST_DIV_INIT: begin
          sh_r      <= {dnum_mag, {tss_pkg::FRAC_BITS{1'b0}}};
          rem_r     <= '0;
          den_mag_r <= piv_mag;
          qneg_r    <= dnum[DW-1] ^ piv_r[DW-1];
          div_cnt_r <= '0;
          state_r   <= (piv_r == '0) ? tss_pkg::ST_DIV_DONE : tss_pkg::ST_DIV_RUN;
        end
        tss_pkg::ST_DIV_RUN: begin
          rem_r     <= take ? DW'(trial - {1'b0, den_mag_r}) : trial[DW-1:0];
          sh_r      <= {sh_r[NUMW-2:0], take};
          div_cnt_r <= div_cnt_r + DCW'(1);
          if (div_cnt_r == DCW'(NUMW - 1)) begin
            state_r <= tss_pkg::ST_DIV_DONE;
          end
        end
        tss_pkg::ST_DIV_DONE: begin
          sing_r <= sing_r | q_ovf;
          if (!div_sel_r) begin
            div_sel_r <= 1'b1;
            state_r   <= tss_pkg::ST_DIV_INIT;
          end else begin
            x_r         <= q_val;
            row_count_r <= {1'b0, idx_r} + tss_pkg::CNTW'(1);
            if (last_r || (idx_r == IDXW'(tss_pkg::MAX_ROWS - 1))) begin
              if (idx_r == '0) begin
                k_r     <= '0;
                state_r <= tss_pkg::ST_EM_RD;
              end else begin
                k_r     <= idx_r - IDXW'(1);
                state_r <= tss_pkg::ST_BS_RD;
              end
            end else begin
              state_r <= tss_pkg::ST_IDLE;
            end
          end
        end
        tss_pkg::ST_BS_RD:  state_r <= tss_pkg::ST_BS_MUL;
        tss_pkg::ST_BS_MUL: state_r <= tss_pkg::ST_BS_SUB;
        tss_pkg::ST_BS_SUB: begin
          x_r    <= bs_s.val;
          sing_r <= sing_r | bs_s.ovf;
          if (k_r == '0) begin
            k_r     <= idx_r;
            state_r <= tss_pkg::ST_EM_RD;
          end else begin
            k_r     <= k_r - IDXW'(1);
            state_r <= tss_pkg::ST_BS_RD;
          end
        end
        tss_pkg::ST_EM_RD: state_r <= tss_pkg::ST_EM_LOAD;
        tss_pkg::ST_EM_LOAD: begin
          if (out_load) begin
            if (k_r == '0) begin
              row_count_r <= '0;
              sing_r      <= 1'b0;
              state_r     <= tss_pkg::ST_IDLE;
            end else begin
              k_r     <= k_r - IDXW'(1);
              state_r <= tss_pkg::ST_EM_RD;
            end
          end
        end
        default: state_r <= tss_pkg::ST_IDLE;
      endcase
    end
  end

  // output register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_solution    <= d_q;
      out_row_index   <= k_r;
      out_last_result <= (k_r == '0);
      out_singular    <= sing_r;
    end
  end

  // checks
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tss_pkg::ST_IDLE) |-> (row_count_r < tss_pkg::CNTW'(tss_pkg::MAX_ROWS)))
    else $error("row count past store depth while idle");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tss_pkg::ST_DIV_RUN) |-> (rem_r < den_mag_r))
    else $error("divider remainder not below divisor");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && (k_r == '0)) |=> (row_count_r == '0) && !sing_r &&
                                  (state_r == tss_pkg::ST_IDLE))
    else $error("run did not close after index zero");

  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tss_pkg::ST_DIV_RUN) |-> (div_cnt_r <= DCW'(NUMW - 1)))
    else $error("divider step count overrun");

endmodule
`default_nettype wire
